### rtl/core/spts_pkg.sv
package spts_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int START_DELAY = 128;
  localparam int BASE_CH     = 4;
  localparam int UNIT_RESET  = 1000;
  localparam int FRAME_RESET = 20000;
  localparam int QDEPTH      = 2;

  localparam int W_W     = 16;
  localparam int TOT_W   = 19;
  localparam int EL_W    = 20;
  localparam int CH_W    = 4;
  localparam int IDX_W   = $clog2(NUM_SLOTS);
  localparam int CNT_W   = $clog2(NUM_SLOTS + BASE_CH + 8);
  localparam int NPREF   = NUM_SLOTS - BASE_CH + 1;
  localparam int PIDX_W  = (NPREF > 1) ? $clog2(NPREF) : 1;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [1:0] CFG_EXTRA  = 2'd0;
  localparam logic [1:0] CFG_SAFETY = 2'd1;
  localparam logic [1:0] CFG_UNIT   = 2'd2;
  localparam logic [1:0] CFG_FRAME  = 2'd3;

  typedef struct packed {
    logic [2:0]  extra_channels;
    logic        safety_hold;
    logic [13:0] width_unit;
    logic [18:0] frame_ticks;
  } cfg_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic [1:0]       action;
    logic [2:0]       channel;
    logic [W_W-1:0]   width;
    logic [TOT_W-1:0] total;
  } entry_t;

  function automatic logic [CNT_W-1:0] active_count(input logic [2:0] extra);
    logic [CNT_W-1:0] n;
    n = CNT_W'(BASE_CH) + CNT_W'(extra);
    if (n > CNT_W'(NUM_SLOTS)) n = CNT_W'(NUM_SLOTS);
    return n;
  endfunction

endpackage

### rtl/core/spts_in_if.sv
interface spts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  channel;
  logic [15:0] width;

  modport source (output valid, action, channel, width, input ready);
  modport sink (input valid, action, channel, width, output ready);
endinterface

### rtl/core/spts_out_if.sv
interface spts_out_if;
  logic        valid;
  logic        ready;
  logic        edge_res;
  logic [3:0]  active_channel;
  logic        reset_line;
  logic        data_line;
  logic        frame_done;
  logic [18:0] total_width;

  modport source (output valid, edge_res, active_channel, reset_line, data_line, frame_done,
                  total_width, input ready);
  modport sink (input valid, edge_res, active_channel, reset_line, data_line, frame_done,
                total_width, output ready);
endinterface

### rtl/core/spts_front.sv
module spts_front
  import spts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  spts_in_if.sink    in_ch,
  input  cfg_t       cfg,
  output logic       push_valid,
  input  logic       push_ready,
  output entry_t     push_data
);

  logic [W_W-1:0]   tbl_r [NUM_SLOTS];
  logic [TOT_W-1:0] pre_r [NPREF];
  logic [TOT_W-1:0] pre_nxt [NPREF];
  logic             accept;
  logic             chan_ok;
  logic             is_set;
  logic [W_W-1:0]   lo;
  logic [W_W-1:0]   hi;
  logic [W_W-1:0]   wclamp;
  logic [W_W-1:0]   old_w;
  logic [CNT_W-1:0] n_act;

  assign accept     = in_ch.valid && push_ready;
  assign in_ch.ready = push_ready;
  assign push_valid = in_ch.valid;

  assign lo = {1'b0, cfg.width_unit, 1'b0};
  assign hi = {cfg.width_unit, 2'b00};

  always_comb begin
    if (in_ch.width < lo) begin
      wclamp = lo;
    end else if (in_ch.width > hi) begin
      wclamp = hi;
    end else begin
      wclamp = in_ch.width;
    end
  end

  assign chan_ok = CNT_W'(in_ch.channel) < CNT_W'(NUM_SLOTS);
  assign is_set  = (in_ch.action == ACT_SET) && chan_ok;
  assign old_w   = tbl_r[IDX_W'(in_ch.channel)];

  // pre_r[j] holds the sum of the first BASE_CH + j stored widths, so a change of
  // the channel count needs no recount.
  always_comb begin
    for (int j = 0; j < NPREF; j++) begin
      if (is_set && (CNT_W'(in_ch.channel) < CNT_W'(BASE_CH + j))) begin
        pre_nxt[j] = pre_r[j] + TOT_W'(wclamp) - TOT_W'(old_w);
      end else begin
        pre_nxt[j] = pre_r[j];
      end
    end
  end

  assign n_act = active_count(cfg.extra_channels);

  always_comb begin
    push_data.action  = in_ch.action;
    push_data.channel = in_ch.channel;
    push_data.width   = wclamp;
    push_data.total   = pre_nxt[PIDX_W'(n_act - CNT_W'(BASE_CH))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) tbl_r[i] <= W_W'(UNIT_RESET);
      for (int j = 0; j < NPREF; j++) pre_r[j] <= TOT_W'((BASE_CH + j) * UNIT_RESET);
    end else if (accept) begin
      if (is_set) tbl_r[IDX_W'(in_ch.channel)] <= wclamp;
      for (int j = 0; j < NPREF; j++) pre_r[j] <= pre_nxt[j];
    end
  end

endmodule

### rtl/core/spts_fifo.sv
module spts_fifo
  import spts_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_data
);

  entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_r;
  logic [QPTR_W-1:0]   rd_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_push;
  logic                do_pop;

  assign push_ready = cnt_r != QCNT_W'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### rtl/core/spts_back.sv
module spts_back
  import spts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  entry_t     pop_data,
  spts_out_if.source out_ch
);

  logic [W_W-1:0]   tbl_r [NUM_SLOTS];
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic [EL_W-1:0]  el_r, el_nxt;
  logic [W_W-1:0]   cd_r, cd_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic             rel_r, rel_nxt;
  logic             edge_nxt;
  logic             data_nxt;
  logic             step;

  logic             ov_r;
  logic             o_edge_r;
  logic [CH_W-1:0]  o_ch_r;
  logic             o_rel_r;
  logic             o_data_r;
  logic             o_done_r;
  logic [TOT_W-1:0] o_tot_r;

  logic [IDX_W-1:0] idx;
  logic [W_W-1:0]   bw;
  logic [EL_W:0]    esum;
  logic [EL_W-1:0]  esat;
  logic [CNT_W-1:0] adv;
  logic [CNT_W-1:0] n_act;

  assign pop_ready = !ov_r || out_ch.ready;
  assign step      = pop_valid && pop_ready;
  assign n_act     = active_count(cfg.extra_channels);

  // A channel index past the table falls back to the last slot.
  assign idx  = (CNT_W'(ch_r) < CNT_W'(NUM_SLOTS)) ? IDX_W'(ch_r) : IDX_W'(NUM_SLOTS - 1);
  assign bw   = tbl_r[idx];
  assign esum = {1'b0, el_r} + (EL_W + 1)'(bw);
  assign esat = esum[EL_W] ? {EL_W{1'b1}} : esum[EL_W-1:0];
  assign adv  = CNT_W'(idx) + 1'b1;

  always_comb begin
    ch_nxt   = ch_r;
    el_nxt   = el_r;
    cd_nxt   = cd_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    rel_nxt  = rel_r;
    edge_nxt = 1'b0;
    data_nxt = 1'b0;
    unique case (pop_data.action)
      ACT_TICK: begin
        if (run_r) begin
          if (cd_r > W_W'(1)) begin
            cd_nxt = cd_r - 1'b1;
          end else begin
            edge_nxt = 1'b1;
            cd_nxt   = bw;
            el_nxt   = esat;
            ch_nxt   = CH_W'(adv);
            // The frame closes only once its time is used up; until then the
            // last channel is timed again.
            if (adv >= n_act) begin
              if ({1'b0, esat} > (EL_W + 1)'(cfg.frame_ticks)) begin
                done_nxt = 1'b1;
                run_nxt  = 1'b0;
              end else begin
                ch_nxt = CH_W'(idx);
              end
            end
          end
        end
      end
      ACT_SET: begin
      end
      ACT_START: begin
        ch_nxt   = '0;
        el_nxt   = '0;
        done_nxt = 1'b0;
        cd_nxt   = W_W'(START_DELAY);
        run_nxt  = 1'b1;
        rel_nxt  = !cfg.safety_hold;
        data_nxt = 1'b1;
      end
      ACT_CLEAR: begin
        done_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) tbl_r[i] <= W_W'(UNIT_RESET);
      ch_r   <= '0;
      el_r   <= '0;
      cd_r   <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
      rel_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (step) begin
        if ((pop_data.action == ACT_SET) &&
            (CNT_W'(pop_data.channel) < CNT_W'(NUM_SLOTS))) begin
          tbl_r[IDX_W'(pop_data.channel)] <= pop_data.width;
        end
        ch_r   <= ch_nxt;
        el_r   <= el_nxt;
        cd_r   <= cd_nxt;
        run_r  <= run_nxt;
        done_r <= done_nxt;
        rel_r  <= rel_nxt;
        ov_r   <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_edge_r <= edge_nxt;
      o_ch_r   <= ch_nxt;
      o_rel_r  <= rel_nxt;
      o_data_r <= data_nxt;
      o_done_r <= done_nxt;
      o_tot_r  <= pop_data.total;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.edge_res       = o_edge_r;
  assign out_ch.active_channel = o_ch_r;
  assign out_ch.reset_line     = o_rel_r;
  assign out_ch.data_line      = o_data_r;
  assign out_ch.frame_done     = o_done_r;
  assign out_ch.total_width    = o_tot_r;

endmodule

### rtl/core/servo_pulse_train_sequencer_top.sv
// Channel  Dir  Beat contents
// in_ch    in   action, channel, width
// out_ch   out  edge_res, active_channel, reset_line, data_line, frame_done, total_width
// cfg      in   cfg_we, cfg_idx, cfg_wdata (write only)
//
// One beat is taken every cycle while the queue has room; results pass the queue and the output register.
// The front clamps widths and keeps the channel totals, the back runs the frame timer.
// A two-entry queue and the output register let either side stall alone.
// Reset is synchronous on rst_n low and restores every register but the queue storage and output data to its default.
module servo_pulse_train_sequencer_top
  import spts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  spts_in_if.sink     in_ch,
  spts_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [18:0] cfg_wdata
);

  cfg_t   cfg_r;
  logic   q_push_valid;
  logic   q_push_ready;
  entry_t q_push_data;
  logic   q_pop_valid;
  logic   q_pop_ready;
  entry_t q_pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.extra_channels <= 3'd0;
      cfg_r.safety_hold    <= 1'b1;
      cfg_r.width_unit     <= 14'(UNIT_RESET);
      cfg_r.frame_ticks    <= 19'(FRAME_RESET);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_EXTRA:  cfg_r.extra_channels <= cfg_wdata[2:0];
        CFG_SAFETY: cfg_r.safety_hold    <= cfg_wdata[0];
        CFG_UNIT:   cfg_r.width_unit     <= cfg_wdata[13:0];
        CFG_FRAME:  cfg_r.frame_ticks    <= cfg_wdata[18:0];
        default: begin
        end
      endcase
    end
  end

  spts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  spts_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  spts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .out_ch    (out_ch)
  );

`ifndef SYNTH
  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data_line) |->
      (!out_ch.edge_res && out_ch.active_channel == '0 && !out_ch.frame_done))
    else $error("start result carries stale frame state");

  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.active_channel <= 4'(NUM_SLOTS)))
    else $error("active channel beyond the table");

  a_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
    !q_push_ready |-> !in_ch.ready)
    else $error("input taken while the queue is full");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop_valid && q_pop_ready) |=> out_ch.valid)
    else $error("popped item produced no result");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import spts_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int TARGET_BEATS = 1850;

  typedef struct packed {
    logic        edge_res;
    logic [3:0]  active_channel;
    logic        reset_line;
    logic        data_line;
    logic        frame_done;
    logic [18:0] total_width;
  } pulse_result_t;

  // Tracks the frame timer and the width table, and holds the results still owed.
  class pulse_scoreboard;
    logic [2:0]  extra;
    logic        safety;
    logic [13:0] unit;
    logic [18:0] frame_min;
    logic [15:0] widths [NUM_SLOTS];
    int unsigned chan_idx;
    int unsigned elapsed;
    int unsigned countdown;
    bit          running;
    bit          done;
    bit          released;
    pulse_result_t pending [$];
    int errors;
    int checked;
    int frames_ended;

    function new();
      extra     = 3'd0;
      safety    = 1'b1;
      unit      = 14'(UNIT_RESET);
      frame_min = 19'(FRAME_RESET);
      foreach (widths[i]) widths[i] = 16'(UNIT_RESET);
      chan_idx     = 0;
      elapsed      = 0;
      countdown    = 0;
      running      = 1'b0;
      done         = 1'b0;
      released     = 1'b0;
      errors       = 0;
      checked      = 0;
      frames_ended = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [18:0] value);
      case (idx)
        CFG_EXTRA:  extra = value[2:0];
        CFG_SAFETY: safety = value[0];
        CFG_UNIT:   unit = value[13:0];
        default:    frame_min = value;
      endcase
    endfunction

    function int unsigned active_channels();
      int unsigned n;
      n = BASE_CH + extra;
      return (n > NUM_SLOTS) ? NUM_SLOTS : n;
    endfunction

    function void note_beat(logic [1:0] act, logic [2:0] ch, logic [15:0] w);
      pulse_result_t r;
      int unsigned lo, hi, req, idx, sum, i;
      r = '0;
      case (act)
        ACT_TICK: begin
          if (running) begin
            if (countdown > 1) begin
              countdown--;
            end else begin
              r.edge_res = 1'b1;
              idx = (chan_idx < NUM_SLOTS) ? chan_idx : NUM_SLOTS - 1;
              countdown = widths[idx];
              elapsed = elapsed + widths[idx];
              if (elapsed > 32'hFFFFF) elapsed = 32'hFFFFF;
              chan_idx = idx + 1;
              // Past the last channel the frame only closes once the minimum is exceeded.
              if (chan_idx >= active_channels()) begin
                if (elapsed > frame_min) begin
                  done = 1'b1;
                  running = 1'b0;
                  frames_ended++;
                end else begin
                  chan_idx = idx;
                end
              end
            end
          end
        end
        ACT_SET: begin
          lo = unit * 2;
          hi = unit * 4;
          req = w;
          if (req < lo) req = lo;
          else if (req > hi) req = hi;
          if (ch < NUM_SLOTS) widths[ch] = req[15:0];
        end
        ACT_START: begin
          chan_idx = 0;
          elapsed = 0;
          done = 1'b0;
          countdown = START_DELAY;
          running = 1'b1;
          released = !safety;
          r.data_line = 1'b1;
        end
        default: done = 1'b0;
      endcase
      sum = 0;
      for (i = 0; i < active_channels(); i++) sum += widths[i];
      if (sum > 32'h7FFFF) sum = 32'h7FFFF;
      r.active_channel = chan_idx[3:0];
      r.reset_line = released;
      r.frame_done = done;
      r.total_width = sum[18:0];
      pending.push_back(r);
    endfunction

    function void check_result(pulse_result_t got);
      pulse_result_t want;
      if (pending.size() == 0) begin
        $error("result beat arrived with no expectation pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.edge_res !== want.edge_res) begin
        $error("edge_res: expected %0d, got %0d", want.edge_res, got.edge_res);
        errors++;
      end
      if (got.active_channel !== want.active_channel) begin
        $error("active_channel: expected %0d, got %0d", want.active_channel,
               got.active_channel);
        errors++;
      end
      if (got.reset_line !== want.reset_line) begin
        $error("reset_line: expected %0d, got %0d", want.reset_line, got.reset_line);
        errors++;
      end
      if (got.data_line !== want.data_line) begin
        $error("data_line: expected %0d, got %0d", want.data_line, got.data_line);
        errors++;
      end
      if (got.frame_done !== want.frame_done) begin
        $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
        errors++;
      end
      if (got.total_width !== want.total_width) begin
        $error("total_width: expected %0d, got %0d", want.total_width, got.total_width);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [18:0] cfg_wdata;

  spts_in_if  in_ch ();
  spts_out_if out_ch ();

  servo_pulse_train_sequencer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  pulse_scoreboard sb;
  pulse_result_t   seen;
  int idle_mode = 0;
  int stall_left = 0;
  int beats_sent = 0;
  int cfg_writes = 0;
  int phases_run = 0;
  int cycle_count = 0;

  // Each column is one register setting; extra 7 and a zero unit probe the limits.
  int ph_extra [7] = '{0, 4, 7, 2, 1, 3, 0};
  int ph_safe  [7] = '{0, 1, 0, 1, 0, 1, 0};
  int ph_unit  [7] = '{1, 3, 0, 16383, 5, 2, 9};
  int ph_frame [7] = '{1, 60, 1, 524287, 100, 40, 200};
  int ph_cap   [7] = '{300, 400, 150, 170, 400, 400, 500};

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (idle_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < ((idle_mode == 1) ? 65 : 30)) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A third inside the clamp window, a third anywhere in the field, the rest below the window or at the field ends.
  function automatic logic [15:0] pick_width();
    int r;
    int unsigned lo, hi;
    r = $urandom_range(0, 5);
    lo = sb.unit * 2;
    hi = sb.unit * 4;
    case (r)
      0, 1: return 16'($urandom_range(0, 65535));
      2, 3: return 16'($urandom_range(lo, hi));
      4: return (lo > 0) ? 16'($urandom_range(0, lo - 1)) : 16'd0;
      default: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.edge_res = out_ch.edge_res;
      seen.active_channel = out_ch.active_channel;
      seen.reset_line = out_ch.reset_line;
      seen.data_line = out_ch.data_line;
      seen.frame_done = out_ch.frame_done;
      seen.total_width = out_ch.total_width;
      sb.check_result(seen);
    end
  end

  // Called and returns at a falling edge; valid is left high for a back-to-back beat.
  task automatic put_beat(input logic [1:0] act, input logic [2:0] ch, input logic [15:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.action = act;
    in_ch.channel = ch;
    in_ch.width = w;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_beat(act, ch, w);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic tick_beat();
    put_beat(ACT_TICK, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [18:0] value);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value;
    sb.write_reg(idx, value);
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_frame(input int cap);
    int n, r;
    idle_mode = $urandom_range(0, 2);
    repeat ($urandom_range(1, 4))
      put_beat(ACT_SET, 3'($urandom_range(0, NUM_SLOTS - 1)), pick_width());
    put_beat(ACT_START, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
    n = 0;
    while (sb.running && n < cap && beats_sent < TARGET_BEATS) begin
      r = $urandom_range(0, 199);
      if (r < 184) tick_beat();
      else if (r < 192) put_beat(ACT_SET, 3'($urandom_range(0, 7)), pick_width());
      else if (r < 196) put_beat(ACT_CLEAR, 3'($urandom_range(0, 7)), 16'($urandom));
      else if (r < 198) put_beat(2'($urandom_range(0, 3)), 3'($urandom), 16'($urandom));
      else put_beat(ACT_START, 3'($urandom_range(0, 7)), 16'($urandom));
      n++;
    end
    // A few ticks follow the frame; once it has closed they must leave everything untouched.
    repeat ($urandom_range(0, 6)) tick_beat();
    if ($urandom_range(0, 1) != 0) put_beat(ACT_CLEAR, 3'($urandom), 16'($urandom));
    if ($urandom_range(0, 3) == 0) drain_results();
  endtask

  initial begin
    int k, c;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.channel = 3'd0;
    in_ch.width = 16'd0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_EXTRA;
    cfg_wdata = 19'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening under the reset settings: idle items, clamping at both
    // field ends, a held start, changes inside a running frame and a restart.
    tick_beat();
    put_beat(ACT_CLEAR, 3'd0, 16'd0);
    put_beat(ACT_SET, 3'd0, 16'h0000);
    put_beat(ACT_SET, 3'd7, 16'hFFFF);
    put_beat(ACT_SET, 3'd5, 16'd3000);
    put_beat(ACT_START, 3'd0, 16'd0);
    repeat (3) tick_beat();
    put_beat(ACT_CLEAR, 3'd7, 16'hFFFF);
    put_beat(ACT_SET, 3'd2, 16'd2500);
    put_beat(ACT_START, 3'd7, 16'hFFFF);
    tick_beat();
    put_beat(ACT_SET, 3'd3, 16'd1999);
    put_beat(ACT_SET, 3'd1, 16'd4001);
    tick_beat();

    k = 0;
    while (beats_sent < TARGET_BEATS) begin
      drain_results();
      write_reg(CFG_EXTRA, 19'(ph_extra[k]));
      write_reg(CFG_SAFETY, 19'(ph_safe[k]));
      write_reg(CFG_UNIT, 19'(ph_unit[k]));
      write_reg(CFG_FRAME, 19'(ph_frame[k]));
      for (c = 0; c < NUM_SLOTS; c++) put_beat(ACT_SET, c[2:0], pick_width());
      repeat ($urandom_range(1, 2)) run_frame(ph_cap[k]);
      phases_run++;
      k = (k + 1) % 7;
    end

    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("summary: %0d beats sent, %0d results checked, %0d frames closed normally",
             beats_sent, sb.checked, sb.frames_ended);
    $display("summary: %0d register settings visited with %0d writes", phases_run, cfg_writes);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/spts_pkg.sv
rtl/core/spts_in_if.sv
rtl/core/spts_out_if.sv
rtl/core/spts_front.sv
rtl/core/spts_fifo.sv
rtl/core/spts_back.sv
rtl/core/servo_pulse_train_sequencer_top.sv
bench/tb.sv
